>>> hdl/atp_pkg.sv
package atp_pkg;
  localparam int unsigned PointCount = 50;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned StepW = $clog2(CordicSteps);
  localparam int unsigned IdxW = $clog2(PointCount);
  localparam logic [31:0] AngleEps = 32'd68356;
  localparam logic signed [39:0] CordicK = 40'sd652032874;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  // span / (PointCount-1) as (span * SpanRecip) >> RecipShift, exact for 32-bit span
  localparam int unsigned RecipShift = 38;
  localparam logic [39:0] SpanRecip =
    40'((64'd1 << RecipShift) / 64'(PointCount - 1) + 64'd1);

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] center_dx;
    logic signed [31:0] center_dy;
    logic               clockwise;
  } arc_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;
  } point_t;

  function automatic logic [31:0] atan_tab(input logic [StepW-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;  5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;  5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;  5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;  5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005; 5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction
endpackage

>>> hdl/atp_if.sv
interface atp_arc_if;
  logic valid;
  logic ready;
  atp_pkg::arc_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface atp_point_if;
  logic valid;
  logic ready;
  atp_pkg::point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/atp_cordic.sv
// Shared CORDIC: vectoring (atan2) or rotation (cos/sin), one step a cycle.
module atp_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               vec_i,
  input  logic signed [39:0] x_i,
  input  logic signed [39:0] y_i,
  input  logic [31:0]        z_i,
  output logic               done_o,
  output logic signed [39:0] x_o,
  output logic signed [39:0] y_o,
  output logic [31:0]        z_o
);
  import atp_pkg::*;

  logic                busy_q;
  logic                vec_q;
  logic [StepW-1:0]    step_q;
  logic signed [39:0]  x_q, y_q;
  logic [31:0]         z_q;
  logic                dir_up;
  logic signed [39:0]  xs, ys;

  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;
  // vectoring: dy>0 rotates cw; rotation: z>=0 rotates ccw
  assign dir_up = vec_q ? (y_q > 0) : !z_q[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        vec_q  <= vec_i;
        step_q <= '0;
        x_q    <= x_i;
        y_q    <= y_i;
        z_q    <= z_i;
      end else if (busy_q) begin
        if (vec_q ? dir_up : !dir_up) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
        end
        z_q <= (vec_q == dir_up) ? z_q + atan_tab(step_q) : z_q - atan_tab(step_q);
        if (step_q == StepW'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

>>> hdl/arc_to_points_linearizer_top.sv
// Arc-to-points linearizer. One arc (start, end, center offset from start,
// direction) is taken on arc_i; 50 points on the circle come out on point_o,
// the last one flagged by last_point, or none when the start and end angles
// coincide. Arc input is not ready while an arc is in work. Steps per arc:
// an accept step, a radius square root (one result bit a cycle), then for
// each of the two angles normalize shifts and a CORDIC vectoring run, one
// check step and two steps that split the span into a per-point step by
// reciprocal multiplication. Each point then takes a CORDIC rotation, a
// multiply step, a round/saturate step and a step to the next offset,
// plus any wait for the previous point's transfer. The single shared
// CORDIC serves both the angles and the points.
module arc_to_points_linearizer_top (
  input logic clk_i,
  input logic rst_ni,
  atp_arc_if.sink     arc_i,
  atp_point_if.source point_o
);
  import atp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_NORM, S_VSTART, S_VWAIT, S_CHECK, S_RECIP, S_REM,
    S_ROT, S_RWAIT, S_MUL, S_ADD, S_OUT
  } state_e;

  state_e              state_q;
  arc_t                arc_q;
  logic signed [33:0]  cx_q, cy_q;
  logic [63:0]         rem_q;      // sqrt radicand bits not yet consumed
  logic [31:0]         root_q;
  logic [5:0]          cnt_q;
  logic                second_q;   // 0 -> a1, 1 -> a2
  logic signed [39:0]  vx_q, vy_q;
  logic [31:0]         a1_q, a2_q, span_q;
  logic [IdxW-1:0]     k_q;
  logic [37:0]         num_q;      // sqrt partial remainder
  logic [31:0]         quo_q;      // angle offset of the current point
  logic [31:0]         qs_q;       // span / (PointCount-1)
  logic [5:0]          rs_q;       // span % (PointCount-1)
  logic [5:0]          fr_q;       // running fraction of the offset
  logic                flip_q;
  logic signed [39:0]  cos_q, sin_q;
  logic signed [72:0]  px_q, py_q;
  point_t              out_q;
  logic                out_v_q;

  logic                cs, cd;
  logic                cvec;
  logic signed [39:0]  cxi, cyi, cxo, cyo;
  logic [31:0]         czi, czo;

  atp_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cs), .vec_i(cvec), .x_i(cxi), .y_i(cyi),
    .z_i(czi), .done_o(cd), .x_o(cxo), .y_o(cyo), .z_o(czo)
  );

  // sqrt step: trial = (root<<2 | 1) against the top pair bits
  logic [63:0] r2;
  logic signed [63:0] dx2, dy2;
  assign dx2 = 64'(arc_i.data.center_dx) * 64'(arc_i.data.center_dx);
  assign dy2 = 64'(arc_i.data.center_dy) * 64'(arc_i.data.center_dy);
  assign r2 = dx2 + dy2;

  logic [33:0] sq_trial, sq_acc;
  // rem_q holds the remaining radicand bits in [63:0]; acc in num_q[33:0]
  assign sq_acc   = {num_q[31:0], rem_q[63:62]};
  assign sq_trial = {root_q, 2'b01};

  logic        big;
  assign big = (vx_q >= 40'sh1_0000_0000) || (vx_q <= -40'sh1_0000_0000) ||
               (vy_q >= 40'sh1_0000_0000) || (vy_q <= -40'sh1_0000_0000);

  // span split: quotient by reciprocal multiply, fraction carried per point
  logic [71:0] recip_prod;
  logic [6:0]  fr_sum;
  assign recip_prod = 72'(span_q) * 72'(SpanRecip);
  assign fr_sum     = 7'(fr_q) + 7'(rs_q);

  logic [31:0] t_ang, t_fold;
  assign t_ang  = arc_q.clockwise ? a2_q + quo_q : a2_q - quo_q;
  assign t_fold = ((t_ang + QuarterTurn) & HalfTurn) != 0 ? t_ang - HalfTurn : t_ang;

  logic [31:0] diff;
  assign diff = (a1_q > a2_q) ? a1_q - a2_q : a2_q - a1_q;

  function automatic logic signed [31:0] sat(input logic signed [73:0] v);
    if (v > 74'sd2147483647) return 32'sh7fffffff;
    if (v < -74'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // vectoring starts from the right half plane; a left-half vector is negated
  // and its angle starts at a half turn
  assign cvec = (state_q == S_VSTART);
  assign cs = (state_q == S_VSTART) || (state_q == S_ROT);
  assign cxi = (state_q == S_ROT) ? CordicK : ((vx_q < 0) ? -vx_q : vx_q);
  assign cyi = (state_q == S_ROT) ? 40'sd0 : ((vx_q < 0) ? -vy_q : vy_q);
  assign czi = (state_q == S_ROT) ? t_fold : (vx_q < 0 ? HalfTurn : 32'd0);

  assign arc_i.ready   = (state_q == S_IDLE);
  assign point_o.valid = out_v_q;
  assign point_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      // S_ADD reloads the output register itself
      if (point_o.ready && state_q != S_ADD) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (arc_i.valid) begin
          arc_q  <= arc_i.data;
          cx_q   <= 34'(arc_i.data.start_x) + 34'(arc_i.data.center_dx);
          cy_q   <= 34'(arc_i.data.start_y) + 34'(arc_i.data.center_dy);
          rem_q  <= r2;
          root_q <= '0;
          num_q  <= '0;
          cnt_q  <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_acc >= sq_trial) begin
            num_q  <= 38'(sq_acc - sq_trial);
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            num_q  <= 38'(sq_acc);
            root_q <= {root_q[30:0], 1'b0};
          end
          rem_q <= {rem_q[61:0], 2'b00};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd31) begin
            second_q <= 1'b0;
            vx_q <= -40'(arc_q.center_dx);
            vy_q <= -40'(arc_q.center_dy);
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (vx_q == 0 && vy_q == 0) begin
            if (second_q) begin a2_q <= '0; state_q <= S_CHECK; end
            else begin
              a1_q <= '0; second_q <= 1'b1;
              vx_q <= 40'(40'(arc_q.end_x) - 40'(cx_q));
              vy_q <= 40'(40'(arc_q.end_y) - 40'(cy_q));
            end
          end else if (!big) begin
            vx_q <= vx_q <<< 1;
            vy_q <= vy_q <<< 1;
          end else begin
            state_q <= S_VSTART;
          end
        end
        S_VSTART: state_q <= S_VWAIT;
        S_VWAIT: if (cd) begin
          if (second_q) begin a2_q <= czo; state_q <= S_CHECK; end
          else begin
            a1_q <= czo; second_q <= 1'b1;
            vx_q <= 40'(40'(arc_q.end_x) - 40'(cx_q));
            vy_q <= 40'(40'(arc_q.end_y) - 40'(cy_q));
            state_q <= S_NORM;
          end
        end
        S_CHECK: begin
          span_q <= arc_q.clockwise ? a1_q - a2_q : a2_q - a1_q;
          k_q <= '0;
          if (diff <= AngleEps) state_q <= S_IDLE;
          else begin
            quo_q <= '0;
            fr_q  <= '0;
            state_q <= S_RECIP;
          end
        end
        S_RECIP: begin
          qs_q <= 32'(recip_prod >> RecipShift);
          state_q <= S_REM;
        end
        S_REM: begin
          rs_q <= 6'(span_q - qs_q * 32'(PointCount - 1));
          state_q <= S_ROT;
        end
        S_ROT: begin
          flip_q <= ((t_ang + QuarterTurn) & HalfTurn) != 0;
          state_q <= S_RWAIT;
        end
        S_RWAIT: if (cd) begin
          cos_q <= flip_q ? -cxo : cxo;
          sin_q <= flip_q ? -cyo : cyo;
          state_q <= S_MUL;
        end
        S_MUL: begin
          px_q <= 73'($signed({1'b0, root_q})) * 73'(cos_q) + (73'sd1 <<< 29);
          py_q <= 73'($signed({1'b0, root_q})) * 73'(sin_q) + (73'sd1 <<< 29);
          state_q <= S_ADD;
        end
        S_ADD: if (!out_v_q || point_o.ready) begin
          out_q.point_x <= sat(74'(cx_q) + 74'(px_q >>> 30));
          out_q.point_y <= sat(74'(cy_q) + 74'(py_q >>> 30));
          out_q.last_point <= (k_q == IdxW'(PointCount - 1));
          out_v_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (k_q == IdxW'(PointCount - 1)) state_q <= S_IDLE;
          else begin
            k_q <= k_q + 1'b1;
            // offset(k+1) = offset(k) + span/M, carrying the fraction
            if (fr_sum >= 7'(PointCount - 1)) begin
              fr_q  <= 6'(fr_sum - 7'(PointCount - 1));
              quo_q <= quo_q + qs_q + 32'd1;
            end else begin
              fr_q  <= 6'(fr_sum);
              quo_q <= quo_q + qs_q;
            end
            state_q <= S_ROT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> bench/arc_points_checker.sv
module arc_points_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  atp_arc_if           arc_mon,
  atp_point_if         pt_mon,
  output int unsigned  fail_cnt_o,
  output int unsigned  pending_o
);
  import atp_pkg::*;

  localparam logic [31:0] ArcTan [CordicSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  point_t      expected_pts[$];
  int unsigned fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = expected_pts.size();

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // binary-angle atan2 by vectoring
  function automatic logic [31:0] angle_of(longint dx, longint dy);
    logic [31:0] z;
    longint      xs;
    longint      ys;
    z = '0;
    if (dx == 0 && dy == 0) return '0;
    while (mag(dx) < (longint'(1) << 32) && mag(dy) < (longint'(1) << 32)) begin
      dx = dx * 2;
      dy = dy * 2;
    end
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
      z  = HalfTurn;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = dx >>> i;
      ys = dy >>> i;
      if (dy > 0) begin
        dx += ys; dy -= xs; z += ArcTan[i];
      end else begin
        dx -= ys; dy += xs; z -= ArcTan[i];
      end
    end
    return z;
  endfunction

  // cos/sin in Q2.30 by rotation
  function automatic void rotate(input logic [31:0] t, output longint c, output longint s);
    logic   flip;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    flip = ((t + QuarterTurn) & HalfTurn) != 0;
    if (flip) t = t - HalfTurn;
    x = longint'(CordicK);
    y = 0;
    z = longint'(signed'(t));
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'({32'd0, ArcTan[i]});
      end else begin
        x += ys; y -= xs; z += longint'({32'd0, ArcTan[i]});
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned root_of(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void predict_arc(arc_t a);
    longint          cx, cy, cdx, cdy, radius, c, s;
    logic [31:0]     a1, a2, diff, span, off, t;
    point_t          p;
    cdx    = longint'(a.center_dx);
    cdy    = longint'(a.center_dy);
    cx     = longint'(a.start_x) + cdx;
    cy     = longint'(a.start_y) + cdy;
    radius = longint'(root_of(longint'(unsigned'(cdx * cdx)) + unsigned'(cdy * cdy)));
    a1     = angle_of(-cdx, -cdy);
    a2     = angle_of(longint'(a.end_x) - cx, longint'(a.end_y) - cy);
    diff   = (a1 > a2) ? a1 - a2 : a2 - a1;
    if (diff <= AngleEps) return;  // coinciding angles: no points
    span = a.clockwise ? a1 - a2 : a2 - a1;
    for (int k = 0; k < PointCount; k++) begin
      off = 32'((64'(span) * 64'(k)) / 64'(PointCount - 1));
      t   = a.clockwise ? a2 + off : a2 - off;
      rotate(t, c, s);
      p.point_x    = clamp32(cx + ((radius * c + (longint'(1) << 29)) >>> 30));
      p.point_y    = clamp32(cy + ((radius * s + (longint'(1) << 29)) >>> 30));
      p.last_point = (k == PointCount - 1);
      expected_pts = {expected_pts, p};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      fail_cnt = 0;
    end else begin
      if (arc_mon.valid && arc_mon.ready) predict_arc(arc_mon.data);
      if (pt_mon.valid && pt_mon.ready) begin
        if (expected_pts.size() == 0) begin
          $error("unexpected point x=%0d y=%0d", pt_mon.data.point_x, pt_mon.data.point_y);
          fail_cnt++;
        end else begin
          want = expected_pts.pop_front();
          if (pt_mon.data.point_x !== want.point_x) begin
            $error("point_x expected %0d actual %0d", want.point_x, pt_mon.data.point_x);
            fail_cnt++;
          end
          if (pt_mon.data.point_y !== want.point_y) begin
            $error("point_y expected %0d actual %0d", want.point_y, pt_mon.data.point_y);
            fail_cnt++;
          end
          if (pt_mon.data.last_point !== want.last_point) begin
            $error("last_point expected %0b actual %0b", want.last_point,
                   pt_mon.data.last_point);
            fail_cnt++;
          end
        end
      end
    end
  end
endmodule

>>> bench/arc_to_points_linearizer_top_tb.sv
module arc_to_points_linearizer_top_tb;
  import atp_pkg::*;

  // Random arcs after the directed set
  localparam int RandArcs = 490;

  logic        clk;
  logic        rst_n;
  int unsigned fail_cnt;
  int unsigned pending;
  logic        snd_idle_en;  // sender gaps on/off, toggled in stretches
  logic        rcv_idle_en;  // receiver stalls on/off
  int unsigned pts_seen;

  atp_arc_if   arc_ch ();
  atp_point_if pt_ch ();

  arc_to_points_linearizer_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .arc_i   (arc_ch),
    .point_o (pt_ch)
  );

  arc_points_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .arc_mon    (arc_ch),
    .pt_mon     (pt_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Hard stop for a hung run (505 arcs, up to 50 stalled points each)
  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // signed value of 'bits' bits, sign bit included
  function automatic logic signed [31:0] rnd_bits(int bits);
    return int'($urandom) >>> (32 - bits);
  endfunction

  function automatic logic signed [31:0] corner_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic arc_t mk_arc(int sx, int sy, int ex, int ey, int dx, int dy, bit cw);
    arc_t a;
    a.start_x = sx; a.start_y = sy; a.end_x = ex; a.end_y = ey;
    a.center_dx = dx; a.center_dy = dy; a.clockwise = cw;
    return a;
  endfunction

  // Mostly well-formed arcs at many scales; some coinciding, some raw noise, some corner values.
  function automatic arc_t rand_arc();
    arc_t a;
    int   sc;
    int   kind;
    kind = $urandom_range(0, 19);
    a.clockwise = 1'($urandom_range(0, 1));
    sc = $urandom_range(2, 29);
    a.start_x   = rnd_bits(30);
    a.start_y   = rnd_bits(30);
    a.center_dx = rnd_bits(sc);
    a.center_dy = rnd_bits(sc);
    a.end_x     = a.start_x + a.center_dx + rnd_bits(sc);
    a.end_y     = a.start_y + a.center_dy + rnd_bits(sc);
    if (kind == 15 || kind == 16) begin
      // end on or next to the start: coinciding angles
      a.end_x = a.start_x + $urandom_range(0, 1);
      a.end_y = a.start_y;
    end else if (kind == 17 || kind == 18) begin
      a = arc_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  1'($urandom)});
    end else if (kind == 19) begin
      a.start_x = corner_val(); a.start_y = corner_val();
      a.end_x = corner_val(); a.end_y = corner_val();
      a.center_dx = corner_val(); a.center_dy = corner_val();
    end
    return a;
  endfunction

  // one arc transfer; valid stays high back to back when no gap is drawn
  task automatic send_arc(arc_t a);
    int unsigned gap;
    gap = snd_idle_en ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      arc_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    arc_ch.data  <= a;
    arc_ch.valid <= 1'b1;
    do @(posedge clk); while (!arc_ch.ready);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off so arcs back up at the input
  initial begin
    int unsigned stall;
    bit          held;
    pt_ch.ready = 1'b0;
    held        = 0;
    pts_seen    = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!held && pts_seen >= 300) begin
        held = 1;
        stall = 600;
      end else begin
        stall = rcv_idle_en ? $urandom_range(0, 19) : 0;
      end
      if (stall > 0) begin
        pt_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pt_ch.ready <= 1'b1;
      do @(posedge clk); while (!pt_ch.valid);
      pts_seen++;
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    arc_t directed[$];
    int   n;
    rst_n        = 1'b0;
    arc_ch.valid = 1'b0;
    arc_ch.data  = '0;
    snd_idle_en  = 1'b1;
    rcv_idle_en  = 1'b1;

    // zero offset: center on start, zero radius
    directed = {directed, mk_arc(1000, 2000, 70000, -5000, 0, 0, 1)};
    directed = {directed, mk_arc(-65536, 0, 0, 65536, 0, 0, 0)};
    // end equals start: coinciding angles
    directed = {directed, mk_arc(65536, 0, 65536, 0, -65536, 0, 1)};
    directed = {directed, mk_arc(65536, 0, 65536, 0, -65536, 0, 0)};
    // end at the center: zero vector angle
    directed = {directed, mk_arc(65536, 0, 0, 0, -65536, 0, 1)};
    // quarter and half circles in both directions (axis angles)
    directed = {directed, mk_arc(65536, 0, 0, 65536, -65536, 0, 0)};
    directed = {directed, mk_arc(65536, 0, 0, 65536, -65536, 0, 1)};
    directed = {directed, mk_arc(0, -131072, 0, 131072, 0, 131072, 0)};
    directed = {directed, mk_arc(0, -131072, 0, 131072, 0, 131072, 1)};
    directed = {directed, mk_arc(-65536, 0, 0, -65536, 65536, 0, 1)};
    // field extremes and saturation
    directed = {directed, mk_arc(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h80000000, 1)};
    directed = {directed, mk_arc(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                 32'h7FFFFFFF, 32'h7FFFFFFF, 0)};
    directed = {directed, mk_arc(32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h40000000,
                                 32'hC0000000, 0, 0)};
    directed = {directed, mk_arc(-1, -1, 1, 1, 1, 1, 1)};
    directed = {directed, mk_arc(0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                 32'h80000000, 0)};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_arc(directed[i]);

    for (n = 0; n < RandArcs; n++) begin
      // alternate stretches with and without idling on each side
      if (n % 40 == 0) begin
        snd_idle_en = $urandom_range(0, 2) != 0;
        rcv_idle_en = $urandom_range(0, 2) != 0;
      end
      // once, hold the next arc until every pending point has drained
      if (n == RandArcs / 2) begin
        arc_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(negedge clk);
      end
      send_arc(rand_arc());
    end
    arc_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    // an arc with no points may still be in work; allow its latency
    repeat (4000) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
